// ===== rtl/ffc_pkg.sv =====
// shared types and constants of the flat-field correction block
package ffc_pkg;

   localparam int CHANNELS   = 4;
   localparam int MAX_PIXELS = 65536;
   localparam int CH_W       = $clog2(CHANNELS);
   localparam int IDX_W      = $clog2(MAX_PIXELS);
   localparam int PIX_W      = 16;
   localparam int CNT_W      = 17;
   localparam int SUM_W      = 32;
   localparam int NUM_W      = PIX_W + SUM_W;
   localparam int DEN_W      = CNT_W + PIX_W;
   localparam int QDEPTH     = 2;

   localparam logic       OP_LOAD    = 1'b0;
   localparam logic       OP_CORRECT = 1'b1;
   localparam logic [CNT_W-1:0] COUNT_RESET = CNT_W'(MAX_PIXELS);
   localparam logic [PIX_W-1:0] PIX_MAX     = {PIX_W{1'b1}};

   typedef struct packed {
      logic             op;
      logic [CH_W-1:0]  channel;
      logic [IDX_W-1:0] pixel_index;
      logic [PIX_W-1:0] pixel_value;
   } req_type;

   typedef struct packed {
      logic [PIX_W-1:0] corrected_pixel;
      logic             saturated;
   } rsp_type;

   // one correction job handed from front to back
   typedef struct packed {
      logic             bypass;
      logic [PIX_W-1:0] pix;
      logic [SUM_W-1:0] sum;
      logic [PIX_W-1:0] ff;
      logic [CNT_W-1:0] count;
   } job_type;

   // queue status seen by both sides
   typedef struct packed {
      logic full;
      logic empty;
   } qstat_type;

endpackage

// ===== rtl/flat_field_correction_top.sv =====
// top level of the flat-field correction block
//
// channel  ports                         direction  payload
// req      req_valid req_ready           in         ffc_pkg::req_type
// rsp      rsp_valid rsp_ready           out        ffc_pkg::rsp_type
// csr      csr_write_en csr_write_data   in         pixel_count, 17 bits
//
// load beats leave req_ready high; a correct beat holds req_ready low for the next cycle
// while the store is read, then passes through the back (pop, multiply,
// 48 division steps, output; a bypass job goes from pop straight to output).
// a two-entry job queue lets the front take beats while the back divides.
// after reset a clearing pass zeroes the flat store, req_ready low.
// a held output result stalls the back, and the front once the queue is full.
module flat_field_correction_top (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_ready,
   input  ffc_pkg::req_type          req_payload,
   output logic                      rsp_valid,
   input  logic                      rsp_ready,
   output ffc_pkg::rsp_type          rsp_payload,
   input  logic                      csr_write_en,
   input  logic [ffc_pkg::CNT_W-1:0] csr_write_data
);

   ffc_pkg::qstat_type qstat;
   ffc_pkg::job_type   push_job;
   ffc_pkg::job_type   pop_job;
   logic               push;
   logic               pop;

   ffc_front u_front (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_payload(req_payload),
      .csr_write_en(csr_write_en), .csr_write_data(csr_write_data),
      .qstat(qstat), .push(push), .push_job(push_job)
   );

   ffc_queue u_queue (
      .clock(clock), .reset(reset),
      .push(push), .push_job(push_job), .pop(pop), .pop_job(pop_job), .qstat(qstat)
   );

   ffc_back u_back (
      .clock(clock), .reset(reset), .qstat(qstat), .pop_job(pop_job), .pop(pop),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_payload(rsp_payload)
   );

endmodule

// ===== rtl/ffc_front.sv =====
// front part: accepts items, keeps flat store and channel sums, issues jobs
module ffc_front (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_ready,
   input  ffc_pkg::req_type                  req_payload,
   input  logic                              csr_write_en,
   input  logic [ffc_pkg::CNT_W-1:0]         csr_write_data,
   input  ffc_pkg::qstat_type                qstat,
   output logic                              push,
   output ffc_pkg::job_type                  push_job
);

   logic [ffc_pkg::PIX_W-1:0] mem [ffc_pkg::CHANNELS][ffc_pkg::MAX_PIXELS];
   logic [ffc_pkg::PIX_W-1:0] rd_ff [ffc_pkg::CHANNELS];
   logic [ffc_pkg::SUM_W-1:0] sum_ff [ffc_pkg::CHANNELS];
   logic [ffc_pkg::SUM_W-1:0] sum_in;
   logic [ffc_pkg::CHANNELS-1:0] loaded_ff;
   logic [ffc_pkg::CNT_W-1:0] count_ff;
   logic [ffc_pkg::CNT_W-1:0] eff_count;
   logic                      clr_ff;
   logic [ffc_pkg::IDX_W-1:0] clr_addr_ff;
   logic                      pend_ff;
   ffc_pkg::job_type          pend_job_ff;
   logic [ffc_pkg::CH_W-1:0]  pend_ch_ff;
   logic                      accept;
   logic                      idx_ok;
   logic [ffc_pkg::PIX_W-1:0] ff_val;
   logic [ffc_pkg::SUM_W:0]   sum_add;
   logic [ffc_pkg::SUM_W-1:0] sum_base;
   logic                      do_load;
   logic [ffc_pkg::PIX_W-1:0] rd_sel;

   // handshake and classification
   assign req_ready = !clr_ff && !pend_ff && !qstat.full;
   assign accept    = req_valid && req_ready;
   assign eff_count = (count_ff == '0) ? ffc_pkg::CNT_W'(1) : count_ff;
   assign idx_ok    = {1'b0, req_payload.pixel_index} < eff_count;
   assign do_load   = accept && (req_payload.op == ffc_pkg::OP_LOAD) && idx_ok;
   assign ff_val    = (req_payload.pixel_value == '0) ? ffc_pkg::PIX_W'(1)
                                                      : req_payload.pixel_value;

   // running sum with restart at index zero and saturation
   always_comb begin
      sum_base = (req_payload.pixel_index == '0) ? '0 : sum_ff[req_payload.channel];
      sum_add  = {1'b0, sum_base} + {{(ffc_pkg::SUM_W+1-ffc_pkg::PIX_W){1'b0}}, ff_val};
      sum_in   = sum_add[ffc_pkg::SUM_W] ? {ffc_pkg::SUM_W{1'b1}}
                                         : sum_add[ffc_pkg::SUM_W-1:0];
   end

   // configuration register
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= ffc_pkg::COUNT_RESET;
      end else if (csr_write_en) begin
         count_ff <= csr_write_data;
      end
   end

   // clearing pass over the flat store after reset
   always_ff @(posedge clock) begin
      if (reset) begin
         clr_ff      <= 1'b1;
         clr_addr_ff <= '0;
      end else if (clr_ff) begin
         clr_addr_ff <= clr_addr_ff + 1'b1;
         if (clr_addr_ff == {ffc_pkg::IDX_W{1'b1}}) begin
            clr_ff <= 1'b0;
         end
      end
   end

   // flat store: one write port, registered read of all channels
   always_ff @(posedge clock) begin
      for (int c = 0; c < ffc_pkg::CHANNELS; c++) begin
         if (clr_ff) begin
            mem[c][clr_addr_ff] <= '0;
         end else if (do_load && (req_payload.channel == ffc_pkg::CH_W'(c))) begin
            mem[c][req_payload.pixel_index] <= ff_val;
         end
         rd_ff[c] <= mem[c][req_payload.pixel_index];
      end
   end

   // channel sums and loaded marks
   always_ff @(posedge clock) begin
      if (reset) begin
         loaded_ff <= '0;
         for (int c = 0; c < ffc_pkg::CHANNELS; c++) begin
            sum_ff[c] <= '0;
         end
      end else if (do_load) begin
         sum_ff[req_payload.channel] <= sum_in;
         if (req_payload.pixel_index == '0) begin
            loaded_ff[req_payload.channel] <= 1'b1;
         end
      end
   end

   // correct beat waits for the registered store read
   always_ff @(posedge clock) begin
      if (reset) begin
         pend_ff <= 1'b0;
      end else begin
         pend_ff <= accept && (req_payload.op == ffc_pkg::OP_CORRECT);
      end
      if (accept) begin
         pend_ch_ff         <= req_payload.channel;
         pend_job_ff.bypass <= !idx_ok || !loaded_ff[req_payload.channel];
         pend_job_ff.pix    <= req_payload.pixel_value;
         pend_job_ff.sum    <= sum_ff[req_payload.channel];
         pend_job_ff.ff     <= '0;
         pend_job_ff.count  <= eff_count;
      end
   end

   // job towards the queue, never-written entries read as one
   always_comb begin
      rd_sel      = rd_ff[pend_ch_ff];
      push        = pend_ff;
      push_job    = pend_job_ff;
      push_job.ff = (rd_sel == '0) ? ffc_pkg::PIX_W'(1) : rd_sel;
   end

endmodule

// ===== rtl/ffc_queue.sv =====
// short job queue between front and back
module ffc_queue (
   input  logic               clock,
   input  logic               reset,
   input  logic               push,
   input  ffc_pkg::job_type   push_job,
   input  logic               pop,
   output ffc_pkg::job_type   pop_job,
   output ffc_pkg::qstat_type qstat
);

   localparam int PTR_W = $clog2(ffc_pkg::QDEPTH);

   ffc_pkg::job_type   slot_ff [ffc_pkg::QDEPTH];
   logic [PTR_W-1:0]   wr_ff;
   logic [PTR_W-1:0]   rd_ff;
   logic [PTR_W:0]     cnt_ff;
   logic [PTR_W:0]     cnt_in;

   assign qstat.full  = (cnt_ff == (PTR_W+1)'(ffc_pkg::QDEPTH));
   assign qstat.empty = (cnt_ff == '0);
   assign pop_job     = slot_ff[rd_ff];

   // occupancy
   always_comb begin
      cnt_in = cnt_ff;
      if (push && !pop) begin
         cnt_in = cnt_ff + 1'b1;
      end else if (pop && !push) begin
         cnt_in = cnt_ff - 1'b1;
      end
   end

   // pointers and slots
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         cnt_ff <= cnt_in;
         if (push) begin
            wr_ff <= wr_ff + 1'b1;
         end
         if (pop) begin
            rd_ff <= rd_ff + 1'b1;
         end
      end
      if (push) begin
         slot_ff[wr_ff] <= push_job;
      end
   end

endmodule

// ===== rtl/ffc_back.sv =====
// back part: products, restoring division, bypass, saturation and result register
module ffc_back (
   input  logic               clock,
   input  logic               reset,
   input  ffc_pkg::qstat_type qstat,
   input  ffc_pkg::job_type   pop_job,
   output logic               pop,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output ffc_pkg::rsp_type   rsp_payload
);

   localparam logic [1:0] B_IDLE = 2'd0;
   localparam logic [1:0] B_MUL  = 2'd1;
   localparam logic [1:0] B_DIV  = 2'd2;
   localparam logic [1:0] B_OUT  = 2'd3;
   localparam int STEP_W = $clog2(ffc_pkg::NUM_W);

   logic [1:0]                state_ff;
   ffc_pkg::job_type          job_ff;
   logic [ffc_pkg::NUM_W-1:0] num_ff;
   logic [ffc_pkg::DEN_W-1:0] den_ff;
   logic [ffc_pkg::DEN_W-1:0] rem_ff;
   logic [STEP_W-1:0]         step_ff;
   logic [ffc_pkg::DEN_W:0]   rem_sh;
   logic [ffc_pkg::DEN_W+1:0] diff;
   logic                      qbit;
   logic                      rsp_valid_ff;
   ffc_pkg::rsp_type          rsp_ff;
   ffc_pkg::rsp_type          res;
   logic                      out_load;

   assign pop         = (state_ff == B_IDLE) && !qstat.empty;
   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;
   assign out_load    = (state_ff == B_OUT) && (!rsp_valid_ff || rsp_ready);

   // one division step
   always_comb begin
      rem_sh = {rem_ff, num_ff[ffc_pkg::NUM_W-1]};
      diff   = {1'b0, rem_sh} - {2'b00, den_ff};
      qbit   = !diff[ffc_pkg::DEN_W+1];
   end

   // final result with bypass and clipping
   always_comb begin
      if (job_ff.bypass) begin
         res.corrected_pixel = job_ff.pix;
         res.saturated       = 1'b0;
      end else if (|num_ff[ffc_pkg::NUM_W-1:ffc_pkg::PIX_W]) begin
         res.corrected_pixel = ffc_pkg::PIX_MAX;
         res.saturated       = 1'b1;
      end else begin
         res.corrected_pixel = num_ff[ffc_pkg::PIX_W-1:0];
         res.saturated       = 1'b0;
      end
   end

   // sequencer
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= B_IDLE;
      end else begin
         case (state_ff)
            B_IDLE: begin
               if (pop) begin
                  state_ff <= pop_job.bypass ? B_OUT : B_MUL;
               end
            end
            B_MUL: begin
               state_ff <= B_DIV;
            end
            B_DIV: begin
               if (step_ff == STEP_W'(ffc_pkg::NUM_W-1)) begin
                  state_ff <= B_OUT;
               end
            end
            B_OUT: begin
               if (out_load) begin
                  state_ff <= B_IDLE;
               end
            end
            default: begin
               state_ff <= B_IDLE;
            end
         endcase
      end
   end

   // result valid: set when a result is loaded, cleared once taken
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (out_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   // datapath
   always_ff @(posedge clock) begin
      if (pop) begin
         job_ff <= pop_job;
      end
      if (state_ff == B_MUL) begin
         num_ff  <= job_ff.pix * job_ff.sum;
         den_ff  <= job_ff.count * job_ff.ff;
         rem_ff  <= '0;
         step_ff <= '0;
      end else if (state_ff == B_DIV) begin
         num_ff  <= {num_ff[ffc_pkg::NUM_W-2:0], qbit};
         rem_ff  <= qbit ? diff[ffc_pkg::DEN_W-1:0] : rem_sh[ffc_pkg::DEN_W-1:0];
         step_ff <= step_ff + 1'b1;
      end
      if (out_load) begin
         rsp_ff <= res;
      end
   end

   a_pop_leaves_idle: assert property (@(posedge clock) disable iff (reset)
      pop |=> (state_ff != B_IDLE))
      else $error("back did not start a popped job");

   a_sat_clips: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_ff.saturated) |-> (rsp_ff.corrected_pixel == ffc_pkg::PIX_MAX))
      else $error("saturated result not clipped");

   a_den_nonzero: assert property (@(posedge clock) disable iff (reset)
      (state_ff == B_DIV) |-> (den_ff != '0))
      else $error("division by zero");

endmodule
